// ===== sv/pipc_pkg.sv =====
package pipc_pkg;

  localparam int CoordW    = 31;
  localparam int RadW      = 30;
  localparam int AngW      = 16;
  localparam int MaxPlanes = 16;
  localparam int IdxW      = $clog2(MaxPlanes);

  typedef enum logic [1:0] {
    VERDICT_INSIDE  = 2'd0,
    VERDICT_OUT_Z   = 2'd1,
    VERDICT_OUT_PHI = 2'd2,
    VERDICT_OUT_RAD = 2'd3
  } verdict_t;

  // Query handed from front end to back end
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     early;     // verdict already decided
    verdict_t                 verdict;
  } query_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_FETCH,
    BK_MUL,
    BK_DIV,
    BK_SQ,
    BK_CMP
  } bk_state_t;

endpackage

// ===== sv/pipc_front.sv =====
module pipc_front (
  input  logic                            start,
  input  logic                            cmd,
  input  logic signed [pipc_pkg::CoordW-1:0] point_x,
  input  logic signed [pipc_pkg::CoordW-1:0] point_y,
  input  logic signed [pipc_pkg::CoordW-1:0] point_z,
  input  logic [pipc_pkg::AngW-1:0]       point_angle,
  input  logic [pipc_pkg::AngW-1:0]       start_angle,
  input  logic [pipc_pkg::AngW:0]         opening_angle,
  input  logic signed [pipc_pkg::CoordW-1:0] z_first,
  input  logic signed [pipc_pkg::CoordW-1:0] z_last,
  input  logic                            in_flight,
  input  logic                            q_full,
  output logic                            q_push,
  output pipc_pkg::query_t                q_data,
  output logic                            busy
);
  import pipc_pkg::*;

  logic [AngW-1:0] d;

  // Hold a load off while any query still needs the table
  assign busy   = q_full || (!cmd && in_flight);
  assign q_push = start && !q_full && cmd;
  assign d      = point_angle - start_angle;

  // Classify z range and phi window up front
  always_comb begin
    q_data.x = point_x;
    q_data.y = point_y;
    q_data.z = point_z;
    q_data.early = 1'b1;
    q_data.verdict = VERDICT_INSIDE;
    if (point_z < z_first || point_z > z_last) begin
      q_data.verdict = VERDICT_OUT_Z;
    end else if (!opening_angle[AngW] && ({1'b0, d} > opening_angle)) begin
      q_data.verdict = VERDICT_OUT_PHI;
    end else begin
      q_data.early = 1'b0;
    end
  end
endmodule

// ===== sv/pipc_queue.sv =====
module pipc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pipc_pkg::query_t din,
  input  logic             pop,
  output pipc_pkg::query_t dout,
  output logic             not_empty,
  output logic             full
);
  import pipc_pkg::*;

  query_t    mem [2];
  logic      wptr, rptr;
  logic [1:0] cnt;

  assign full      = (cnt == 2'd2);
  assign not_empty = (cnt != 2'd0);
  assign dout      = mem[rptr];

  // Two-entry queue between classifier and datapath
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== sv/pipc_back.sv =====
module pipc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  pipc_pkg::query_t                q_data,
  output logic                            q_pop,
  output logic                            active,
  input  logic [pipc_pkg::IdxW:0]         n_used,
  output logic [pipc_pkg::IdxW-1:0]       rd_idx,
  input  logic signed [pipc_pkg::CoordW-1:0] rd_h,
  input  logic [pipc_pkg::RadW-1:0]       rd_in,
  input  logic [pipc_pkg::RadW-1:0]       rd_out,
  output logic                            done,
  output logic                            inside_res,
  output logic [1:0]                      verdict
);
  import pipc_pkg::*;

  localparam int DivW = 64;

  bk_state_t state, state_next;
  query_t    q;
  logic [IdxW:0] idx;
  logic [RadW-1:0] in_lo, out_lo, in_hi, out_hi;
  logic signed [CoordW:0] num, span;
  // products (r2-r1)*num, signed, 63 bits fit
  logic signed [DivW-1:0] prod_in, prod_out;
  logic [DivW-1:0] rem_in, rem_out, quo_in, quo_out, dvs;
  logic neg_in, neg_out;
  logic [5:0] bitc;
  logic sel;
  logic [RadW:0] rmin, rmax;
  logic [2*RadW+1:0] rmin2, rmax2;
  logic [2*CoordW:0] rho2;
  logic [CoordW-1:0] ax, ay;
  logic done_next;

  assign rd_idx = idx[IdxW-1:0];
  assign q_pop  = (state == BK_IDLE) && q_valid;
  assign active = (state != BK_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (q_valid && !q_data.early) state_next = BK_SEARCH;
      BK_SEARCH: begin
        if (rd_h >= q.z) state_next = (idx == '0) ? BK_IDLE : BK_FETCH;
        else if (idx == n_used - 1'b1) state_next = BK_IDLE;
      end
      BK_FETCH:  state_next = BK_MUL;
      BK_MUL:    state_next = BK_DIV;
      BK_DIV:    if (bitc == 6'd0) state_next = BK_SQ;
      BK_SQ:     state_next = BK_CMP;
      BK_CMP:    state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // Flag the cycles that finish a query
  always_comb begin
    done_next = 1'b0;
    unique case (state)
      BK_IDLE:   done_next = q_valid && q_data.early;
      BK_SEARCH: done_next = (rd_h >= q.z) ? (idx == '0) : (idx == n_used - 1'b1);
      BK_CMP:    done_next = 1'b1;
      default:   done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= done_next;
  end

  // Restoring divide step on both radii at once
  logic [DivW-1:0] tin, tout;
  assign tin  = {rem_in[DivW-2:0], quo_in[DivW-1]};
  assign tout = {rem_out[DivW-2:0], quo_out[DivW-1]};

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q   <= q_data;
          idx <= '0;
          if (q_data.early) begin
            inside_res <= 1'b0;
            verdict    <= q_data.verdict;
          end
        end
      end
      BK_SEARCH: begin
        // walk planes for first height at or above z
        if (rd_h >= q.z) begin
          if (idx == '0) begin
            inside_res <= 1'b0; verdict <= VERDICT_OUT_RAD;
          end else begin
            span  <= {rd_h[CoordW-1], rd_h};
            in_hi <= rd_in;
            out_hi <= rd_out;
            idx   <= idx - 1'b1;
          end
        end else if (idx == n_used - 1'b1) begin
          inside_res <= 1'b0; verdict <= VERDICT_OUT_RAD;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      BK_FETCH: begin
        in_lo  <= rd_in;
        out_lo <= rd_out;
        num    <= {q.z[CoordW-1], q.z} - {rd_h[CoordW-1], rd_h};
        span   <= span - {rd_h[CoordW-1], rd_h};
      end
      BK_MUL: begin
        prod_in  <= DivW'(($signed({1'b0, in_hi}) - $signed({1'b0, in_lo})) * num);
        prod_out <= DivW'(($signed({1'b0, out_hi}) - $signed({1'b0, out_lo})) * num);
        bitc <= 6'd63;
        sel  <= 1'b0;
      end
      BK_DIV: begin
        if (!sel) begin
          // set up magnitudes
          sel     <= 1'b1;
          neg_in  <= prod_in[DivW-1];
          neg_out <= prod_out[DivW-1];
          quo_in  <= prod_in[DivW-1] ? DivW'(-prod_in) : prod_in;
          quo_out <= prod_out[DivW-1] ? DivW'(-prod_out) : prod_out;
          rem_in  <= '0;
          rem_out <= '0;
          dvs     <= DivW'($unsigned(span));
        end else begin
          if (tin >= dvs) begin
            rem_in <= tin - dvs; quo_in <= {quo_in[DivW-2:0], 1'b1};
          end else begin
            rem_in <= tin; quo_in <= {quo_in[DivW-2:0], 1'b0};
          end
          if (tout >= dvs) begin
            rem_out <= tout - dvs; quo_out <= {quo_out[DivW-2:0], 1'b1};
          end else begin
            rem_out <= tout; quo_out <= {quo_out[DivW-2:0], 1'b0};
          end
          bitc <= bitc - 6'd1;
        end
      end
      BK_SQ: begin
        rmin <= (RadW+1)'($signed({1'b0, in_lo}) +
                (neg_in ? -$signed(quo_in) : $signed(quo_in)));
        rmax <= (RadW+1)'($signed({1'b0, out_lo}) +
                (neg_out ? -$signed(quo_out) : $signed(quo_out)));
        ax <= q.x[CoordW-1] ? CoordW'(-q.x) : q.x;
        ay <= q.y[CoordW-1] ? CoordW'(-q.y) : q.y;
      end
      BK_CMP: begin
        if (rho2 > {1'b0, rmax2[2*CoordW-1:0]} || rho2 < {1'b0, rmin2[2*CoordW-1:0]}) begin
          inside_res <= 1'b0; verdict <= VERDICT_OUT_RAD;
        end else begin
          inside_res <= 1'b1; verdict <= VERDICT_INSIDE;
        end
      end
      default: ;
    endcase
  end

  // Squares feed the final compare
  always_comb begin
    rmin2 = (2*RadW+2)'(rmin * rmin);
    rmax2 = (2*RadW+2)'(rmax * rmax);
    rho2  = (2*CoordW+1)'(ax * ax) + (2*CoordW+1)'(ay * ay);
  end
endmodule

// ===== sv/point_in_polycone_test_core.sv =====
// Channel | Signals                                   | Handshake
// input   | cmd, plane_*, point_*                    | start & !busy
// result  | inside_res, verdict                      | done, one cycle
// config  | psel penable pwrite paddr pwdata prdata  | APB, pready high
// Loads are written into the table when accepted. A query deciding on z or
// phi has its done strobe registered once the back end pops it from the queue;
// others search for the bracket plane, then run the 64-step restoring divider.
// A two-entry queue lets the front accept while the back works; busy rises
// when the queue is full, and for a load while any query is queued or in the
// back end. Reset is synchronous; table contents are undefined until loaded.
// The receiver cannot stall.
module point_in_polycone_test_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [3:0]  plane_slot,
  input  logic signed [30:0] plane_height,
  input  logic [29:0] plane_inner,
  input  logic [29:0] plane_outer,
  input  logic signed [30:0] point_x,
  input  logic signed [30:0] point_y,
  input  logic signed [30:0] point_z,
  input  logic [15:0] point_angle,
  output logic        done,
  output logic        inside_res,
  output logic [1:0]  verdict,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pipc_pkg::*;

  localparam logic [1:0] RegCount = 2'd0, RegStart = 2'd1, RegOpen = 2'd2;

  logic [4:0]  plane_count;
  logic [15:0] start_angle;
  logic [16:0] opening_angle;
  logic signed [CoordW-1:0] height_table [MaxPlanes];
  logic [RadW-1:0] inner_table [MaxPlanes];
  logic [RadW-1:0] outer_table [MaxPlanes];
  logic [IdxW:0] n_used;
  logic [IdxW-1:0] rd_idx, last_idx;
  logic q_push, q_pop, q_full, q_valid;
  logic back_active, in_flight;
  query_t q_in, q_out;

  assign pready = 1'b1;

  // Register writes and reads
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count   <= 5'd2;
      start_angle   <= '0;
      opening_angle <= 17'h10000;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegCount: plane_count   <= pwdata[4:0];
        RegStart: start_angle   <= pwdata[15:0];
        RegOpen:  opening_angle <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegCount: prdata = {27'd0, plane_count};
      RegStart: prdata = {16'd0, start_angle};
      RegOpen:  prdata = {15'd0, opening_angle};
      default:  prdata = '0;
    endcase
  end

  // Clamp plane count
  always_comb begin
    if (plane_count < 5'd2) n_used = (IdxW+1)'(2);
    else if (32'(plane_count) > MaxPlanes) n_used = (IdxW+1)'(MaxPlanes);
    else n_used = (IdxW+1)'(plane_count);
  end

  assign last_idx  = IdxW'(n_used - 1'b1);
  assign in_flight = q_valid || back_active;

  // Plane table loads
  always_ff @(posedge clk) begin
    if (start && !busy && !cmd && (32'(plane_slot) < MaxPlanes)) begin
      height_table[plane_slot[IdxW-1:0]] <= plane_height;
      inner_table[plane_slot[IdxW-1:0]]  <= plane_inner;
      outer_table[plane_slot[IdxW-1:0]]  <= plane_outer;
    end
  end

  pipc_front u_front (
    .start, .cmd, .point_x, .point_y, .point_z, .point_angle,
    .start_angle, .opening_angle,
    .z_first(height_table[0]),
    .z_last(height_table[last_idx]),
    .in_flight, .q_full, .q_push, .q_data(q_in), .busy
  );

  pipc_queue u_queue (
    .clk, .rst, .push(q_push), .din(q_in), .pop(q_pop), .dout(q_out),
    .not_empty(q_valid), .full(q_full)
  );

  pipc_back u_back (
    .clk, .rst, .q_valid, .q_data(q_out), .q_pop, .active(back_active), .n_used, .rd_idx,
    .rd_h(height_table[rd_idx]), .rd_in(inner_table[rd_idx]),
    .rd_out(outer_table[rd_idx]), .done, .inside_res, .verdict
  );
endmodule
